/* src/cpa_pkg.sv */
// Shared constants and controller/datapath interface types for the CPU pool allocator.
package cpa_pkg;

  // Default number of worker slots.
  localparam int MAX_WORKERS_DEF = 8;

  // Action codes on the action port.
  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_ALLOCATE = 2'd1;
  localparam logic [1:0] ACT_PREEMPT  = 2'd2;
  localparam logic [1:0] ACT_RELEASE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_WORKER = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input word and restart the scan
    logic scan;    // step the slot scan by one entry
    logic commit;  // apply the decision and register the result word
  } cpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // the last slot is being evaluated this cycle
  } cpa_stat_t;

endpackage

/* src/cpu_pool_allocator_with_preemption_unit.sv */
// Top level of the CPU pool allocator with burst-estimate preemption.
//
// Usage: drive action and its operand ports and raise start; the word is
// taken at a rising edge where start is high and busy is low. Actions are
// register a worker, allocate the first free worker, allocate by preempting
// the busy worker with the largest estimate if it exceeds the new one, and release a pid.
// Each accepted word gives exactly one result word, presented on status,
// granted_dispatch, evict_flag, evicted_pid and evict_interrupt for one cycle
// while done is high. The receiver cannot stall; it must take the word then.
// Sequence: the accepted word passes through the slot scan, which reads one
// slot per cycle from the slot memories with a registered read, then the
// commit state and the result register. busy falls in the done cycle, so a
// new word may be accepted then.
// Reset (rst, synchronous) empties the table: all slots invalid and free.
// The worker id given with register is accepted but not kept, since no
// result depends on it.
module cpu_pool_allocator_with_preemption_unit
  import cpa_pkg::*;
#(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  cpu_id,
  input  logic [15:0] dispatch_handle,
  input  logic [15:0] interrupt_handle,
  input  logic [31:0] process_id,
  input  logic [31:0] burst_estimate,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] granted_dispatch,
  output logic        evict_flag,
  output logic [31:0] evicted_pid,
  output logic [15:0] evict_interrupt
);

  cpa_cmd_t  cmd;
  cpa_stat_t stat;

  // Sequencer.
  cpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Slot tables and result registers.
  cpa_datapath #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .action           (action),
    .dispatch_handle  (dispatch_handle),
    .interrupt_handle (interrupt_handle),
    .process_id       (process_id),
    .burst_estimate   (burst_estimate),
    .done             (done),
    .status           (status),
    .granted_dispatch (granted_dispatch),
    .evict_flag       (evict_flag),
    .evicted_pid      (evicted_pid),
    .evict_interrupt  (evict_interrupt)
  );

endmodule

/* src/cpa_ctrl.sv */
// Controller state machine of the CPU pool allocator: accept, scan, commit.
module cpa_ctrl
  import cpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  cpa_stat_t stat,
  output cpa_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands to the datapath.
  assign busy       = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && start;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.commit = (state == S_COMMIT);

endmodule

/* src/cpa_datapath.sv */
// Datapath of the CPU pool allocator: slot tables, scan pipeline and result registers.
module cpa_datapath
  import cpa_pkg::*;
#(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cpa_cmd_t    cmd,
  output cpa_stat_t   stat,
  input  logic [1:0]  action,
  input  logic [15:0] dispatch_handle,
  input  logic [15:0] interrupt_handle,
  input  logic [31:0] process_id,
  input  logic [31:0] burst_estimate,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] granted_dispatch,
  output logic        evict_flag,
  output logic [31:0] evicted_pid,
  output logic [15:0] evict_interrupt
);

  localparam int IDXW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNTW = $clog2(MAX_WORKERS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_WORKERS - 1);
  localparam logic [CNTW-1:0] END_CNT  = CNTW'(MAX_WORKERS);

  // Per-slot flags, cleared by reset.
  logic [MAX_WORKERS-1:0] slot_valid;
  logic [MAX_WORKERS-1:0] slot_busy;

  // Slot memories: {dispatch, interrupt} and {pid, estimate}.
  logic [31:0] handle_mem [MAX_WORKERS];
  logic [63:0] run_mem    [MAX_WORKERS];
  logic [31:0] handle_q;
  logic [63:0] run_q;

  // Captured input word.
  logic [1:0]  act;
  logic [15:0] in_disp;
  logic [15:0] in_int;
  logic [31:0] in_pid;
  logic [31:0] in_est;

  // Scan pipeline.
  logic [CNTW-1:0] rd_idx;
  logic [IDXW-1:0] eval_idx;
  logic            eval_en;

  // Best or first match found so far.
  logic            found;
  logic [IDXW-1:0] pick;
  logic [15:0]     pick_disp;
  logic [15:0]     pick_int;
  logic [31:0]     pick_pid;
  logic [31:0]     pick_est;

  logic [15:0] cur_disp;
  logic [15:0] cur_int;
  logic [31:0] cur_pid;
  logic [31:0] cur_est;
  logic        cur_valid;
  logic        cur_busy;
  logic        hit;
  logic        take;
  logic        preempt_ok;

  assign cur_disp  = handle_q[31:16];
  assign cur_int   = handle_q[15:0];
  assign cur_pid   = run_q[63:32];
  assign cur_est   = run_q[31:0];
  assign cur_valid = slot_valid[eval_idx];
  assign cur_busy  = slot_busy[eval_idx];

  assign stat.scan_done = eval_en && (eval_idx == LAST_IDX);

  // Match condition of the slot under evaluation for the current action.
  always_comb begin
    hit  = 1'b0;
    take = 1'b0;
    case (act)
      ACT_REGISTER: hit = !cur_valid;
      ACT_ALLOCATE: hit = cur_valid && !cur_busy;
      ACT_PREEMPT:  hit = cur_valid && cur_busy && (!found || (cur_est > pick_est));
      ACT_RELEASE:  hit = cur_valid && cur_busy && (cur_pid == in_pid);
      default:      hit = 1'b0;
    endcase
    // Preemption keeps the largest estimate; the others keep the first hit.
    if (act == ACT_PREEMPT) begin
      take = eval_en && hit;
    end else begin
      take = eval_en && hit && !found;
    end
  end

  assign preempt_ok = found && (pick_est > in_est);

  // Input capture and scan address counter.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act     <= action;
      in_disp <= dispatch_handle;
      in_int  <= interrupt_handle;
      in_pid  <= process_id;
      in_est  <= burst_estimate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      eval_en <= 1'b0;
      found   <= 1'b0;
    end else if (cmd.load) begin
      rd_idx  <= '0;
      eval_en <= 1'b0;
      found   <= 1'b0;
    end else if (cmd.scan) begin
      if (rd_idx != END_CNT) begin
        rd_idx  <= rd_idx + CNTW'(1);
        eval_en <= 1'b1;
      end else begin
        eval_en <= 1'b0;
      end
      if (take) found <= 1'b1;
    end else begin
      eval_en <= 1'b0;
    end
  end

  // Index of the slot whose data is in the read registers, and the chosen slot.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      eval_idx <= rd_idx[IDXW-1:0];
    end
    if (cmd.scan && take) begin
      pick      <= eval_idx;
      pick_disp <= cur_disp;
      pick_int  <= cur_int;
      pick_pid  <= cur_pid;
      pick_est  <= cur_est;
    end
  end

  // Slot memories: registered reads during the scan, writes at commit.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      handle_q <= handle_mem[rd_idx[IDXW-1:0]];
      run_q    <= run_mem[rd_idx[IDXW-1:0]];
    end
    if (cmd.commit && found && (act == ACT_REGISTER)) begin
      handle_mem[pick] <= {in_disp, in_int};
    end
    if (cmd.commit && (((act == ACT_ALLOCATE) && found) ||
                       ((act == ACT_PREEMPT) && preempt_ok))) begin
      run_mem[pick] <= {in_pid, in_est};
    end
  end

  // Slot flags updated at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_busy  <= '0;
    end else if (cmd.commit && found) begin
      case (act)
        ACT_REGISTER: begin
          slot_valid[pick] <= 1'b1;
          slot_busy[pick]  <= 1'b0;
        end
        ACT_ALLOCATE: slot_busy[pick] <= 1'b1;
        ACT_PREEMPT:  slot_busy[pick] <= 1'b1;
        ACT_RELEASE:  slot_busy[pick] <= 1'b0;
        default:      slot_busy[pick] <= slot_busy[pick];
      endcase
    end
  end

  // Result word, shown for one cycle after commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status           <= ST_OK;
      granted_dispatch <= '0;
      evict_flag       <= 1'b0;
      evicted_pid      <= '0;
      evict_interrupt  <= '0;
      case (act)
        ACT_REGISTER: begin
          if (!found) status <= ST_FULL;
        end
        ACT_ALLOCATE: begin
          if (found) granted_dispatch <= pick_disp;
          else       status <= ST_NO_WORKER;
        end
        ACT_PREEMPT: begin
          if (preempt_ok) begin
            granted_dispatch <= pick_disp;
            evict_flag       <= 1'b1;
            evicted_pid      <= pick_pid;
            evict_interrupt  <= pick_int;
          end else begin
            status <= ST_NO_WORKER;
          end
        end
        ACT_RELEASE: begin
          if (!found) status <= ST_NOT_FOUND;
        end
        default: status <= ST_OK;
      endcase
    end
  end

endmodule
